// ===== rtl/wlfu_pkg.sv =====
// ============================================================================
// wlfu_pkg
// Shared types, widths and operation codes for the windowed LFU slot
// replacement block.
// ============================================================================
package wlfu_pkg;

    // Slot cache geometry
    localparam int SLOTS          = 6;
    localparam int SLOT_W         = 3;
    localparam int FILL_W         = $clog2(SLOTS + 1);
    localparam int DEFAULT_WINDOW = 100;

    // Payload widths
    localparam int OP_W   = 2;
    localparam int RULE_W = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_HIT   = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [RULE_W-1:0] rule_t;

endpackage

// ===== rtl/wlfu_req_if.sv =====
// ============================================================================
// wlfu_req_if
// Request channel: operation, matched slot and rule number.
// ============================================================================
interface wlfu_req_if import wlfu_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    slot_idx_t          hit_slot;
    rule_t              rule_index;

    modport source (output valid, output operation, output hit_slot,
                    output rule_index, input ready);
    modport sink   (input valid, input operation, input hit_slot,
                    input rule_index, output ready);

endinterface

// ===== rtl/wlfu_rsp_if.sv =====
// ============================================================================
// wlfu_rsp_if
// Response channel: slot used, eviction report and status flags.
// ============================================================================
interface wlfu_rsp_if import wlfu_pkg::*; ();

    logic       valid;
    logic       ready;
    slot_idx_t  slot;
    logic       evicted;
    rule_t      old_rule;
    logic       recorded;
    logic       bad_request;

    modport source (output valid, output slot, output evicted, output old_rule,
                    output recorded, output bad_request, input ready);
    modport sink   (input valid, input slot, input evicted, input old_rule,
                    input recorded, input bad_request, output ready);

endinterface

// ===== rtl/wlfu_victim.sv =====
// ============================================================================
// wlfu_victim
// Pick the slot with the lowest use count; lowest index wins a tie.
// ============================================================================
module wlfu_victim import wlfu_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
)
(
    input  logic [$clog2(WINDOW+1)-1:0] counts [SLOTS],
    output slot_idx_t                   victim
);

    localparam int CNT_W = $clog2(WINDOW + 1);

    logic [CNT_W-1:0] best;

    // Strict compare keeps the earliest slot on a tie
    always_comb
    begin
        best   = CNT_W'(WINDOW);
        victim = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (counts[i] < best)
            begin
                best   = counts[i];
                victim = SLOT_W'(i);
            end
        end
    end

endmodule

// ===== rtl/windowed_lfu_slot_replacement.sv =====
// ============================================================================
// windowed_lfu_slot_replacement
// Sliding-window LFU replacement policy for a small cache of rule slots.
// ============================================================================
// Each request passes through the transfer cycle, in which the
// oldest entry of the use-history ring is read from its synchronous memory,
// and the execute cycle, in which counts are updated, the new use is written
// back to the ring and the response is loaded into the output register. A
// new request is taken the cycle after execute, so requests never overlap;
// execute holds for as long as an earlier response still waits in the
// output register. The ring holds the last WINDOW uses and is never
// cleared: the fill length guarantees that only written entries are read.
// A hit on a slot that was never filled returns bad_request and leaves all
// state alone. Clear empties slots, counts and ring.
// ============================================================================
module windowed_lfu_slot_replacement import wlfu_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
)
(
    input  logic          clk,
    input  logic          rst_n,
    wlfu_req_if.sink      req,
    wlfu_rsp_if.source    rsp
);

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int LEN_W  = $clog2(WINDOW + 1);
    localparam int HIST_W = $clog2(WINDOW);
    localparam int SUM_W  = LEN_W + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Control state
    logic                  state_reg,   state_next;
    logic [FILL_W-1:0]     filled_reg,  filled_next;
    logic [HIST_W-1:0]     head_reg,    head_next;
    logic [LEN_W-1:0]      len_reg,     len_next;
    logic [CNT_W-1:0]      count_reg [SLOTS];
    logic [CNT_W-1:0]      count_next [SLOTS];
    rule_t                 rule_reg [SLOTS];
    rule_t                 rule_next [SLOTS];

    // Captured request
    logic [OP_W-1:0]       op_reg;
    slot_idx_t             hs_reg;
    rule_t                 ri_reg;

    // Response register
    logic                  rsp_valid_reg;
    slot_idx_t             rsp_slot_reg,     rsp_slot_next;
    logic                  rsp_evicted_reg,  rsp_evicted_next;
    rule_t                 rsp_old_rule_reg, rsp_old_rule_next;
    logic                  rsp_recorded_reg, rsp_recorded_next;
    logic                  rsp_bad_reg,      rsp_bad_next;

    // History ring
    slot_idx_t             hist_mem [WINDOW];
    slot_idx_t             hist_rdata_reg;
    logic                  hist_we;
    logic [HIST_W-1:0]     hist_waddr;
    slot_idx_t             hist_wdata;

    // Execute datapath
    logic                  req_xfer;
    logic                  finish;
    slot_idx_t             victim;
    slot_idx_t             use_slot;
    logic                  fresh_fill;
    logic                  do_record;
    logic                  recorded;
    logic                  ring_full;
    logic [CNT_W-1:0]      cur_count;
    logic [CNT_W-1:0]      base;
    logic [HIST_W-1:0]     head_inc;
    logic [SUM_W-1:0]      tail_sum;
    logic [HIST_W-1:0]     tail_addr;
    logic                  do_clear;

    assign req_xfer  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // Execute may complete only when the output register is free or draining
    assign finish = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp.ready);

    wlfu_victim #(
        .WINDOW (WINDOW)
    ) u_victim (
        .counts (count_reg),
        .victim (victim)
    );

    // ------------------------------------------------------------------
    // Ring pointers
    // ------------------------------------------------------------------
    assign ring_full = (len_reg == LEN_W'(WINDOW));
    assign head_inc  = (head_reg == HIST_W'(WINDOW - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(len_reg);
    assign tail_addr = (tail_sum >= SUM_W'(WINDOW))
                     ? HIST_W'(tail_sum - SUM_W'(WINDOW))
                     : HIST_W'(tail_sum);

    // ------------------------------------------------------------------
    // Execute: decide the slot, update counts, push the use
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        filled_next       = filled_reg;
        head_next         = head_reg;
        len_next          = len_reg;
        count_next        = count_reg;
        rule_next         = rule_reg;
        rsp_slot_next     = '0;
        rsp_evicted_next  = 1'b0;
        rsp_old_rule_next = '0;
        rsp_recorded_next = 1'b0;
        rsp_bad_next      = 1'b0;
        hist_we           = 1'b0;
        hist_waddr        = tail_addr;
        hist_wdata        = '0;
        use_slot          = '0;
        fresh_fill        = 1'b0;
        do_record         = 1'b0;
        do_clear          = 1'b0;
        recorded          = 1'b0;
        cur_count         = '0;
        base              = '0;

        case (op_reg)
            OP_HIT:
            begin
                use_slot      = hs_reg;
                rsp_slot_next = hs_reg;
                if (FILL_W'(hs_reg) >= filled_reg || hs_reg >= SLOT_W'(SLOTS))
                    rsp_bad_next = 1'b1;
                else
                    do_record = 1'b1;
            end
            OP_FILL:
            begin
                do_record = 1'b1;
                if (filled_reg < FILL_W'(SLOTS))
                begin
                    fresh_fill = 1'b1;
                    use_slot   = SLOT_W'(filled_reg);
                end
                else
                begin
                    use_slot          = victim;
                    rsp_evicted_next  = 1'b1;
                    rsp_old_rule_next = rule_reg[victim];
                end
                rsp_slot_next = use_slot;
            end
            OP_CLEAR:
            begin
                do_clear = 1'b1;
            end
            default:
            begin
                do_record = 1'b0;
            end
        endcase

        // Saturation is judged before any pop
        if (do_record)
        begin
            cur_count = fresh_fill ? '0 : count_reg[use_slot];
            recorded  = (cur_count < CNT_W'(WINDOW));
        end
        rsp_recorded_next = recorded;

        if (finish)
        begin
            state_next = ST_IDLE;
            if (do_clear)
            begin
                filled_next = '0;
                head_next   = '0;
                len_next    = '0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    count_next[i] = '0;
                    rule_next[i]  = '0;
                end
            end
            else if (do_record)
            begin
                if (fresh_fill)
                    filled_next = filled_reg + 1'b1;
                // Only a fill stores a new rule; a hit leaves the rule alone
                if (op_reg == OP_FILL)
                    rule_next[use_slot] = ri_reg;
                for (int i = 0; i < SLOTS; i++)
                begin
                    base = (fresh_fill && use_slot == SLOT_W'(i)) ? '0 : count_reg[i];
                    if (recorded && ring_full && hist_rdata_reg == SLOT_W'(i)
                        && base != '0)
                        base = base - 1'b1;
                    if (recorded && use_slot == SLOT_W'(i))
                        base = base + 1'b1;
                    count_next[i] = base;
                end
                if (recorded)
                begin
                    hist_we    = 1'b1;
                    hist_wdata = use_slot;
                    // Full ring: the new use overwrites the oldest one
                    if (ring_full)
                    begin
                        hist_waddr = head_reg;
                        head_next  = head_inc;
                    end
                    else
                    begin
                        len_next = len_reg + 1'b1;
                    end
                end
            end
        end
        else if (req_xfer)
        begin
            state_next = ST_EXEC;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filled_reg    <= '0;
            head_reg      <= '0;
            len_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                count_reg[i] <= '0;
                rule_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
            head_reg   <= head_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            rule_reg   <= rule_next;
            // Load wins over drain: finish only fires when the register frees
            if (finish)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload registers: capture on transfer, load on finish
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg <= req.operation;
            hs_reg <= req.hit_slot;
            ri_reg <= req.rule_index;
        end
        if (finish)
        begin
            rsp_slot_reg     <= rsp_slot_next;
            rsp_evicted_reg  <= rsp_evicted_next;
            rsp_old_rule_reg <= rsp_old_rule_next;
            rsp_recorded_reg <= rsp_recorded_next;
            rsp_bad_reg      <= rsp_bad_next;
        end
    end

    // History ring: one write port, registered read of the oldest entry
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= hist_wdata;
        hist_rdata_reg <= hist_mem[head_reg];
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.slot        = rsp_slot_reg;
    assign rsp.evicted     = rsp_evicted_reg;
    assign rsp.old_rule    = rsp_old_rule_reg;
    assign rsp.recorded    = rsp_recorded_reg;
    assign rsp.bad_request = rsp_bad_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(WINDOW))
        else $error("history length beyond window");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < HIST_W'(WINDOW))
        else $error("history head out of range");

    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FILL_W'(SLOTS))
        else $error("filled slot count beyond slot total");

    a_xfer_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> (state_reg == ST_EXEC))
        else $error("accepted request did not enter execute");

    a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_bad_reg) |-> (!rsp_recorded_reg && !rsp_evicted_reg))
        else $error("bad request reported a use or eviction");

endmodule
